// ----- design/stack_language_tokenizer_defines.svh -----
// Assertion macros used by the checker module.
`ifndef STACK_LANGUAGE_TOKENIZER_DEFINES_SVH
`define STACK_LANGUAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define STL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, switched off while reset is asserted.
`define STL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also holds across reset.
`define STL_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- design/stl_pkg.sv -----
package stl_pkg;

  localparam int POS_BITS   = 32;
  localparam int WORD_BYTES = 7;
  localparam int WORD_BITS  = 8 * WORD_BYTES;
  localparam int FIFO_DEPTH = 4;
  localparam int NUM_KEYWORDS = 20;

  // Input item kinds.
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  // Token kinds.
  localparam logic [4:0] K_ILLEGAL  = 5'd0;
  localparam logic [4:0] K_PLUS     = 5'd1;
  localparam logic [4:0] K_MINUS    = 5'd2;
  localparam logic [4:0] K_STAR     = 5'd3;
  localparam logic [4:0] K_SLASH    = 5'd4;
  localparam logic [4:0] K_PAREN    = 5'd5;
  localparam logic [4:0] K_AT       = 5'd6;
  localparam logic [4:0] K_NEWLINE  = 5'd7;
  localparam logic [4:0] K_FF       = 5'd8;
  localparam logic [4:0] K_NUMBER   = 5'd9;
  localparam logic [4:0] K_STRING   = 5'd10;
  localparam logic [4:0] K_IDENT    = 5'd11;
  localparam logic [4:0] K_KEYWORD0 = 5'd12;

  // Characters with a role of their own.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_BTICK   = 8'h60;
  localparam logic [7:0] CH_FF      = 8'hFF;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        is_last;
  } tok_t;

  // Up to two tokens produced by one accepted item.
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

  // Keywords packed right-aligned, first byte most significant.
  localparam logic [WORD_BITS-1:0] KEYWORDS [NUM_KEYWORDS] = '{
    56'h0000_6d61_6372_6f, // macro
    56'h0000_0000_656e_64, // end
    56'h0065_7874_6572_6e, // extern
    56'h0069_6e74_6572_6e, // intern
    56'h0000_0000_7375_62, // sub
    56'h0065_6e64_7375_62, // endsub
    56'h0000_676f_7375_62, // gosub
    56'h6a75_6d70_7375_62, // jumpsub
    56'h0072_6574_7572_6e, // return
    56'h0000_0067_6f74_6f, // goto
    56'h0000_656d_7074_79, // empty
    56'h0000_0064_726f_70, // drop
    56'h0000_0073_7761_70, // swap
    56'h0000_0000_6475_70, // dup
    56'h0000_0000_0065_71, // eq
    56'h0000_0000_6e65_71, // neq
    56'h0000_0000_0068_69, // hi
    56'h0000_0068_6965_71, // hieq
    56'h0000_0000_006c_77, // lw
    56'h0000_006c_7765_71  // lweq
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_PLUS:              k = K_PLUS;
      CH_MINUS:             k = K_MINUS;
      CH_STAR:              k = K_STAR;
      CH_SLASH:             k = K_SLASH;
      CH_LPAREN, CH_RPAREN: k = K_PAREN;
      CH_AT:                k = K_AT;
      CH_NEWLINE:           k = K_NEWLINE;
      CH_FF:                k = K_FF;
      default:              k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] word_kind(logic [WORD_BITS-1:0] w, logic too_long);
    logic [4:0] k;
    k = K_IDENT;
    if (!too_long) begin
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
        if (w == KEYWORDS[i]) k = K_KEYWORD0 + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- design/stl_if.sv -----
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic        is_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output is_last, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input is_last, output ready);
endinterface

// ----- design/stl_scanner.sv -----
module stl_scanner import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output tok_pair_t  toks
);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_TAIL, M_COMMENT
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [31:0]           ostart_r, ostart_nxt;
  logic [31:0]           olen_r, olen_nxt;
  logic                  oill_r, oill_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic                  wlong_r, wlong_nxt;

  logic        close_v, take_close, single_v, used;
  logic [4:0]  close_kind, single_k;
  logic [31:0] pos32, olen_inc;
  tok_t        close_tok, single_tok;

  assign pos32    = 32'(pos_r);
  assign olen_inc = (olen_r == 32'hFFFF_FFFF) ? olen_r : olen_r + 32'd1;

  always_comb begin
    close_v    = 1'b0;
    close_kind = K_ILLEGAL;
    unique case (mode_r)
      M_IDENT: begin
        close_v    = 1'b1;
        close_kind = word_kind(word_r, wlong_r);
      end
      M_NUMBER: begin
        close_v    = 1'b1;
        close_kind = oill_r ? K_ILLEGAL : K_NUMBER;
      end
      M_STRING, M_TAIL: begin
        close_v    = 1'b1;
        close_kind = oill_r ? K_ILLEGAL : K_STRING;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    oill_nxt   = oill_r;
    word_nxt   = word_r;
    wlong_nxt  = wlong_r;
    take_close = 1'b0;
    single_v   = 1'b0;
    single_k   = K_ILLEGAL;
    used       = 1'b1;
    if (accept) begin
      if (in_kind == ITEM_END) begin
        take_close = close_v;
        mode_nxt   = M_IDLE;
        pos_nxt    = '0;
      end else begin
        unique case (mode_r)
          M_COMMENT: begin
            if (in_byte == CH_QMARK || in_byte == CH_NEWLINE) mode_nxt = M_IDLE;
          end
          M_IDENT: begin
            if (is_ident(in_byte)) begin
              if (olen_r < 32'(WORD_BYTES)) begin
                word_nxt = {word_r[WORD_BITS-9:0], in_byte};
              end else begin
                wlong_nxt = 1'b1;
              end
              olen_nxt = olen_inc;
            end else begin
              used = 1'b0;
            end
          end
          M_NUMBER: begin
            if (is_alpha(in_byte) || is_digit(in_byte)) begin
              if (is_alpha(in_byte)) oill_nxt = 1'b1;
              olen_nxt = olen_inc;
            end else begin
              used = 1'b0;
            end
          end
          M_STRING: begin
            if (in_byte == CH_BTICK || in_byte == CH_NUL) begin
              mode_nxt = M_TAIL;
            end else begin
              olen_nxt = olen_inc;
            end
          end
          M_TAIL: begin
            if (is_ident(in_byte)) begin
              oill_nxt = 1'b1;
              olen_nxt = olen_inc;
            end else begin
              used = 1'b0;
            end
          end
          default: used = 1'b0;
        endcase

        // The byte did not extend the open token: close it and start over.
        if (!used) begin
          take_close = close_v;
          mode_nxt   = M_IDLE;
          priority if (in_byte == CH_QMARK) begin
            mode_nxt = M_COMMENT;
          end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
            mode_nxt = M_IDLE;
          end else if (is_digit(in_byte)) begin
            mode_nxt   = M_NUMBER;
            ostart_nxt = pos32;
            olen_nxt   = 32'd1;
            oill_nxt   = 1'b0;
          end else if (in_byte == CH_BTICK) begin
            mode_nxt   = M_STRING;
            ostart_nxt = pos32 + 32'd1;
            olen_nxt   = 32'd0;
            oill_nxt   = 1'b0;
          end else if (is_alpha(in_byte) || in_byte == CH_UNDER) begin
            mode_nxt   = M_IDENT;
            ostart_nxt = pos32;
            olen_nxt   = 32'd1;
            oill_nxt   = 1'b0;
            word_nxt   = {{(WORD_BITS-8){1'b0}}, in_byte};
            wlong_nxt  = 1'b0;
          end else begin
            single_v = 1'b1;
            single_k = single_kind(in_byte);
          end
        end
        pos_nxt = pos_r + POS_BITS'(1);
      end
    end
  end

  always_comb begin
    close_tok.token_kind   = close_kind;
    close_tok.token_start  = ostart_r;
    close_tok.token_length = olen_r;
    close_tok.is_last      = !single_v;
    single_tok.token_kind   = single_k;
    single_tok.token_start  = pos32;
    single_tok.token_length = 32'd1;
    single_tok.is_last      = 1'b1;
    toks.n  = 2'(take_close) + 2'(single_v);
    toks.t0 = take_close ? close_tok : single_tok;
    toks.t1 = single_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      ostart_r <= '0;
      olen_r   <= '0;
      oill_r   <= 1'b0;
      word_r   <= '0;
      wlong_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      ostart_r <= ostart_nxt;
      olen_r   <= olen_nxt;
      oill_r   <= oill_nxt;
      word_r   <= word_nxt;
      wlong_r  <= wlong_nxt;
    end
  end

endmodule

// ----- design/stl_token_fifo.sv -----
module stl_token_fifo import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tok_pair_t push,
  input  logic      pop,
  output tok_t      head,
  output logic      not_empty,
  output logic      room2
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tok_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);
  assign head      = mem_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  // Ready for the next item only if both possible tokens fit.
  assign room2     = count_r <= CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.t0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_r + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

endmodule

// ----- design/stack_language_tokenizer.sv -----
// A token is written into the token queue by the input transfer that closes it and is offered once it is at the head.
// Throughput: one input item per cycle while the output keeps up; an item that yields
// two tokens is offered as two separate output tokens, and input ready drops while the four-entry token
// queue has fewer than two free entries.
// Reset: synchronous, active low; clears scan state, position and the token queue.
module stack_language_tokenizer import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_bus,
  stl_out_if.source out_bus
);

  tok_pair_t toks;
  tok_t      head;
  logic      accept, not_empty, room2;

  assign in_bus.ready = room2;
  assign accept       = in_bus.valid && room2;

  stl_scanner u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_kind (in_bus.kind),
    .in_byte (in_bus.byte_value),
    .toks    (toks)
  );

  stl_token_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (toks),
    .pop       (not_empty && out_bus.ready),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_bus.valid        = not_empty;
  assign out_bus.token_kind   = head.token_kind;
  assign out_bus.token_start  = head.token_start;
  assign out_bus.token_length = head.token_length;
  assign out_bus.is_last      = head.is_last;

endmodule

// ----- design/stl_checker.sv -----
`include "stack_language_tokenizer_defines.svh"

module stl_checker import stl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_token_kind,
  input logic [31:0] out_token_start,
  input logic [31:0] out_token_length,
  input logic        out_is_last
);

  // A stalled token stays offered and unchanged.
  `STL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `STL_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
                  $stable(out_token_kind) && $stable(out_token_start) &&
                  $stable(out_token_length) && $stable(out_is_last))
  // Reset empties the queue and reopens the input.
  `STL_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && in_ready)
  // Single-byte tokens always span exactly one byte.
  `STL_ASSERT_IMP(a_single_len, out_valid && out_token_kind >= K_PLUS &&
                  out_token_kind <= K_FF, out_token_length == 32'd1)
  // Keywords are two to seven bytes long.
  `STL_ASSERT_IMP(a_keyword_len, out_valid && out_token_kind >= K_KEYWORD0,
                  out_token_length >= 32'd2 && out_token_length <= 32'd7)

endmodule

bind stack_language_tokenizer stl_checker u_stl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_token_kind   (out_bus.token_kind),
  .out_token_start  (out_bus.token_start),
  .out_token_length (out_bus.token_length),
  .out_is_last      (out_bus.is_last)
);

// ----- tb/stack_language_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module stack_language_tokenizer_tb;
  import stl_pkg::*;

  localparam int RANDOM_ITEMS   = 1050;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_TAIL, SCAN_COMMENT
  } scan_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } item_t;

  typedef struct {
    logic       kind;
    logic [7:0] value;
    logic       typed;
    tok_t       want;
  } vector_t;

  localparam tok_t NO_TOKEN = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stl_in_if  in_bus ();
  stl_out_if out_bus ();

  stack_language_tokenizer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string kw_names [NUM_KEYWORDS] = '{
    "macro", "end", "extern", "intern", "sub", "endsub", "gosub",
    "jumpsub", "return", "goto", "empty", "drop", "swap", "dup",
    "eq", "neq", "hi", "hieq", "lw", "lweq"
  };

  // Rows with a typed token yield exactly that one token from a clean position.
  vector_t directed [25] = '{
    '{ITEM_BYTE, CH_PLUS,    1'b1, '{K_PLUS,    32'd0,  32'd1, 1'b1}},
    '{ITEM_BYTE, CH_NUL,     1'b1, '{K_ILLEGAL, 32'd1,  32'd1, 1'b1}},
    '{ITEM_BYTE, CH_FF,      1'b1, '{K_FF,      32'd2,  32'd1, 1'b1}},
    '{ITEM_BYTE, 8'h65,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, 8'h71,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_SPACE,   1'b0, NO_TOKEN},
    '{ITEM_BYTE, 8'h39,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, 8'h61,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_MINUS,   1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_BTICK,   1'b0, NO_TOKEN},
    '{ITEM_BYTE, 8'h78,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_NUL,     1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_UNDER,   1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_TAB,     1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_QMARK,   1'b0, NO_TOKEN},
    '{ITEM_BYTE, 8'h7A,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_NEWLINE, 1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_AT,      1'b1, '{K_AT,      32'd17, 32'd1, 1'b1}},
    '{ITEM_BYTE, CH_BTICK,   1'b0, NO_TOKEN},
    '{ITEM_END,  8'h00,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_QMARK,   1'b0, NO_TOKEN},
    '{ITEM_END,  8'hA5,      1'b0, NO_TOKEN},
    '{ITEM_END,  8'h5A,      1'b0, NO_TOKEN},
    '{ITEM_BYTE, CH_SLASH,   1'b1, '{K_SLASH,   32'd0,  32'd1, 1'b1}},
    '{ITEM_BYTE, CH_LPAREN,  1'b1, '{K_PAREN,   32'd1,  32'd1, 1'b1}}
  };

  // Tokenizer state as seen by the prediction.
  scan_t                 scan = SCAN_IDLE;
  logic [POS_BITS-1:0]   next_pos = '0;
  logic [31:0]           span_start = '0;
  logic [31:0]           span_len = '0;
  logic                  span_bad = 1'b0;
  logic [WORD_BITS-1:0]  word_bytes = '0;
  logic                  word_long = 1'b0;

  tok_t  item_tokens [$];
  tok_t  pending_tokens [$];
  item_t fragment_items [$];

  int  errors = 0;
  int  tokens_seen = 0;
  int  idle_count = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;
  bit  long_hold_done = 1'b0;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_letter(c) || is_numeral(c) || c == CH_UNDER;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [4:0] lone_kind(logic [7:0] c);
    case (c)
      CH_PLUS:              return K_PLUS;
      CH_MINUS:             return K_MINUS;
      CH_STAR:              return K_STAR;
      CH_SLASH:             return K_SLASH;
      CH_LPAREN, CH_RPAREN: return K_PAREN;
      CH_AT:                return K_AT;
      CH_NEWLINE:           return K_NEWLINE;
      CH_FF:                return K_FF;
      default:              return K_ILLEGAL;
    endcase
  endfunction

  function automatic logic [4:0] keyword_lookup();
    logic [WORD_BITS-1:0] kw_bits;
    if (word_long) return K_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      kw_bits = '0;
      for (int j = 0; j < kw_names[i].len() && j < WORD_BYTES; j++) begin
        kw_bits = {kw_bits[WORD_BITS-9:0], 8'(kw_names[i][j])};
      end
      if (kw_bits == word_bytes) return K_KEYWORD0 + 5'(i);
    end
    return K_IDENT;
  endfunction

  function automatic void add_token(logic [4:0] kind, logic [31:0] start, logic [31:0] len);
    tok_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.is_last      = 1'b0;
    item_tokens = {item_tokens, t};
  endfunction

  function automatic void close_span();
    case (scan)
      SCAN_WORD:   add_token(keyword_lookup(), span_start, span_len);
      SCAN_NUMBER: add_token(span_bad ? K_ILLEGAL : K_NUMBER, span_start, span_len);
      SCAN_STRING,
      SCAN_TAIL:   add_token(span_bad ? K_ILLEGAL : K_STRING, span_start, span_len);
      default: ;
    endcase
    scan = SCAN_IDLE;
  endfunction

  function automatic void open_span(scan_t mode, logic [31:0] start, logic [31:0] len);
    scan       = mode;
    span_start = start;
    span_len   = len;
    span_bad   = 1'b0;
  endfunction

  // Works out the tokens that one accepted item yields and leaves them in item_tokens.
  function automatic void scan_item(logic kind, logic [7:0] b);
    logic        consumed;
    logic [31:0] pos;
    item_tokens.delete();
    pos = next_pos[31:0];
    if (kind == ITEM_END) begin
      close_span();
      next_pos = '0;
    end else begin
      consumed = 1'b1;
      case (scan)
        SCAN_COMMENT: begin
          if (b == CH_QMARK || b == CH_NEWLINE) scan = SCAN_IDLE;
        end
        SCAN_WORD: begin
          if (is_word_char(b)) begin
            if (span_len < WORD_BYTES) word_bytes = {word_bytes[WORD_BITS-9:0], b};
            else word_long = 1'b1;
            span_len = bump(span_len);
          end else begin
            consumed = 1'b0;
          end
        end
        SCAN_NUMBER: begin
          if (is_letter(b) || is_numeral(b)) begin
            if (is_letter(b)) span_bad = 1'b1;
            span_len = bump(span_len);
          end else begin
            consumed = 1'b0;
          end
        end
        SCAN_STRING: begin
          if (b == CH_BTICK || b == CH_NUL) scan = SCAN_TAIL;
          else span_len = bump(span_len);
        end
        SCAN_TAIL: begin
          if (is_word_char(b)) begin
            span_bad = 1'b1;
            span_len = bump(span_len);
          end else begin
            consumed = 1'b0;
          end
        end
        default: begin
          scan = SCAN_IDLE;
          consumed = 1'b0;
        end
      endcase

      if (!consumed) begin
        close_span();
        if (b == CH_QMARK) begin
          scan = SCAN_COMMENT;
        end else if (is_numeral(b)) begin
          open_span(SCAN_NUMBER, pos, 32'd1);
        end else if (b == CH_BTICK) begin
          open_span(SCAN_STRING, pos + 32'd1, 32'd0);
        end else if (is_letter(b) || b == CH_UNDER) begin
          open_span(SCAN_WORD, pos, 32'd1);
          word_bytes = {{(WORD_BITS-8){1'b0}}, b};
          word_long  = 1'b0;
        end else if (b != CH_SPACE && b != CH_TAB) begin
          add_token(lone_kind(b), pos, 32'd1);
        end
      end
      next_pos = next_pos + 1'b1;
    end
    if (item_tokens.size() > 0) item_tokens[item_tokens.size()-1].is_last = 1'b1;
  endfunction

  function automatic int gap_length(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_error(string why, tok_t want, tok_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("ERROR %s: expected kind %0d start %0d len %0d last %0b",
               why, want.token_kind, want.token_start, want.token_length, want.is_last);
      $display("  got kind %0d start %0d len %0d last %0b",
               got.token_kind, got.token_start, got.token_length, got.is_last);
    end
  endfunction

  function automatic logic [7:0] pick_word_char();
    int idx;
    idx = $urandom_range(0, 62);
    if (idx < 26) return 8'h61 + 8'(idx);
    if (idx < 52) return 8'h41 + 8'(idx - 26);
    if (idx < 62) return 8'h30 + 8'(idx - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_letter();
    int idx;
    idx = $urandom_range(0, 51);
    return (idx < 26) ? 8'h61 + 8'(idx) : 8'h41 + 8'(idx - 26);
  endfunction

  function automatic void queue_item(logic kind, logic [7:0] b);
    item_t it;
    it.kind  = kind;
    it.value = b;
    fragment_items = {fragment_items, it};
  endfunction

  function automatic void push_byte(logic [7:0] b);
    queue_item(ITEM_BYTE, b);
  endfunction

  // Builds one piece of source text: mostly well-formed tokens, some noise.
  function automatic void build_fragment();
    int          roll;
    int          len;
    int          slot;
    logic [7:0]  b;
    logic [7:0]  ops [9];
    string       kw;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
            CH_AT, CH_NEWLINE, CH_FF};
    fragment_items.delete();
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      kw = kw_names[$urandom_range(0, NUM_KEYWORDS - 1)];
      for (int i = 0; i < kw.len(); i++) push_byte(8'(kw[i]));
      if ($urandom_range(0, 4) == 0) push_byte(pick_word_char());
    end else if (roll < 30) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      push_byte(($urandom_range(0, 7) == 0) ? CH_UNDER : pick_letter());
      for (int i = 1; i < len; i++) push_byte(pick_word_char());
    end else if (roll < 42) begin
      len  = $urandom_range(1, 6);
      slot = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) : -1;
      push_byte(8'h30 + 8'($urandom_range(0, 9)));
      for (int i = 1; i <= len; i++) begin
        if (i == slot) push_byte(pick_letter());
        else if (i < len) push_byte(8'h30 + 8'($urandom_range(0, 9)));
      end
    end else if (roll < 54) begin
      push_byte(CH_BTICK);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(1, 255));
        push_byte((b == CH_BTICK) ? CH_UNDER : b);
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) push_byte(CH_BTICK);
      else if (roll < 85) push_byte(CH_NUL);
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_byte(pick_word_char());
      end
    end else if (roll < 62) begin
      push_byte(CH_QMARK);
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        push_byte((b == CH_QMARK || b == CH_NEWLINE) ? CH_SPACE : b);
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) push_byte(CH_QMARK);
      else if (roll < 9) push_byte(CH_NEWLINE);
    end else if (roll < 78) begin
      push_byte(ops[$urandom_range(0, 8)]);
    end else if (roll < 90) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end else if (roll < 97) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      queue_item(ITEM_END, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) push_byte(CH_SPACE);
  endfunction

  // Offers one item, waits for its transfer, then records the tokens it should yield.
  task automatic offer_item(input logic kind, input logic [7:0] value,
                            input logic typed, input tok_t want);
    int gap;
    if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
    gap = gap_length(send_steady);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= kind;
    in_bus.byte_value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    scan_item(kind, value);
    if (typed) begin
      pending_tokens = {pending_tokens, want};
    end else begin
      foreach (item_tokens[i]) pending_tokens = {pending_tokens, item_tokens[i]};
    end
  endtask

  initial begin : main_sequence
    int sent;
    in_bus.valid      <= 1'b0;
    in_bus.kind       <= ITEM_BYTE;
    in_bus.byte_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      offer_item(directed[i].kind, directed[i].value, directed[i].typed, directed[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_fragment();
      foreach (fragment_items[i]) begin
        offer_item(fragment_items[i].kind, fragment_items[i].value, 1'b0, NO_TOKEN);
        sent++;
      end
    end
    in_bus.valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_tokens.size() != 0)
      report_error("token never arrived", pending_tokens.pop_front(), NO_TOKEN);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : token_sink
    int   stall;
    tok_t got;
    stall = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.token_kind, out_bus.token_start, out_bus.token_length, out_bus.is_last};
        tokens_seen++;
        if (pending_tokens.size() == 0) report_error("unexpected token", NO_TOKEN, got);
        else if (got !== pending_tokens[0]) report_error("token mismatch", pending_tokens[0], got);
        if (pending_tokens.size() != 0) void'(pending_tokens.pop_front());
      end
      if ($urandom_range(0, 99) == 0) recv_steady = !recv_steady;
      // One long hold-off lets the token queue fill so the input has to stall.
      if (!long_hold_done && tokens_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0) begin
        stall = gap_length(recv_steady);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

// ----- stack_language_tokenizer.f -----
+incdir+design
design/stl_pkg.sv
design/stl_if.sv
design/stl_scanner.sv
design/stl_token_fifo.sv
design/stack_language_tokenizer.sv
design/stl_checker.sv
tb/stack_language_tokenizer_tb.sv
